FILE: design/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types, byte constants and the grammar transition function for the
// shell command line validator.
// ----------------------------------------------------------------------------
package scv_pkg;

    // Grammar state, one-hot
    typedef enum logic [4:0] {
        GS_EXPECT_CMD  = 5'b00001,
        GS_IN_CMD      = 5'b00010,
        GS_NEED_TARGET = 5'b00100,
        GS_AFTER_AMP   = 5'b01000,
        GS_ERROR       = 5'b10000
    } t_gs;

    // Operator held for one byte of lookahead
    typedef enum logic [1:0] {
        PEND_NONE = 2'b00,
        PEND_AMP  = 2'b01,
        PEND_GT   = 2'b10
    } t_pend;

    // Token kinds fed to the grammar
    typedef enum logic [2:0] {
        TK_NAME   = 3'd0,
        TK_AMP    = 3'd1,
        TK_ANDAND = 3'd2,
        TK_PIPE   = 3'd3,
        TK_REDIR  = 3'd4
    } t_tok;

    // Byte codes
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_AMP   = 8'h26;
    localparam logic [7:0] C_LT    = 8'h3C;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_PIPE  = 8'h7C;

    // One grammar transition for one token
    function automatic t_gs take_token(input t_gs s, input t_tok tk);
        t_gs n;
        n = GS_ERROR;
        unique case (s)
            GS_EXPECT_CMD, GS_NEED_TARGET, GS_AFTER_AMP: begin
                if (tk == TK_NAME) n = GS_IN_CMD;
            end
            GS_IN_CMD: begin
                priority if (tk == TK_NAME)                      n = GS_IN_CMD;
                else if (tk == TK_REDIR)                         n = GS_NEED_TARGET;
                else if (tk == TK_PIPE || tk == TK_ANDAND)       n = GS_EXPECT_CMD;
                else if (tk == TK_AMP)                           n = GS_AFTER_AMP;
                else                                             n = GS_ERROR;
            end
            default: n = GS_ERROR;
        endcase
        return n;
    endfunction

    // Whitespace: tab through carriage return, and space
    function automatic logic is_space(input logic [7:0] c);
        return (c == C_SPACE) || (c >= C_TAB && c <= C_CR);
    endfunction

endpackage

FILE: design/scv_step.sv
// ----------------------------------------------------------------------------
// scv_step
// Lexer and grammar state for one line; consumes one byte word per enable
// and reports the verdict combinationally on the final byte.
// ----------------------------------------------------------------------------
module scv_step (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_ok
);
    import scv_pkg::*;

    t_gs   r_gs,      n_gs;
    t_pend r_pend,    n_pend;
    logic  r_in_name, n_in_name;
    logic  r_stop,    n_stop;

    t_gs   gs_a;
    t_pend pend_a;
    t_gs   gs_f;

    // Byte step: two-byte operators, flush of the held operator, then the byte
    always_comb begin
        gs_a      = r_gs;
        pend_a    = r_pend;
        n_in_name = r_in_name;
        n_stop    = r_stop;
        if (!r_stop) begin
            priority if (r_pend == PEND_AMP && i_ch == C_AMP) begin
                pend_a = PEND_NONE;
                gs_a   = take_token(r_gs, TK_ANDAND);
            end else if (r_pend == PEND_GT && i_ch == C_GT) begin
                pend_a = PEND_NONE;
                gs_a   = take_token(r_gs, TK_REDIR);
            end else begin
                if (r_pend == PEND_AMP)     gs_a = take_token(r_gs, TK_AMP);
                else if (r_pend == PEND_GT) gs_a = take_token(r_gs, TK_REDIR);
                pend_a = PEND_NONE;
                priority if (i_ch == C_NUL) begin
                    n_stop    = 1'b1;
                    n_in_name = 1'b0;
                end else if (is_space(i_ch)) begin
                    n_in_name = 1'b0;
                end else if (i_ch == C_AMP) begin
                    n_in_name = 1'b0;
                    pend_a    = PEND_AMP;
                end else if (i_ch == C_GT) begin
                    n_in_name = 1'b0;
                    pend_a    = PEND_GT;
                end else if (i_ch == C_PIPE) begin
                    n_in_name = 1'b0;
                    gs_a      = take_token(gs_a, TK_PIPE);
                end else if (i_ch == C_LT) begin
                    n_in_name = 1'b0;
                    gs_a      = take_token(gs_a, TK_REDIR);
                end else begin
                    // name byte: only the first of a run is a token
                    n_in_name = 1'b1;
                    if (!r_in_name) gs_a = take_token(gs_a, TK_NAME);
                end
            end
        end
    end

    // End of line: flush the held operator and judge
    always_comb begin
        gs_f = gs_a;
        if (pend_a == PEND_AMP)     gs_f = take_token(gs_a, TK_AMP);
        else if (pend_a == PEND_GT) gs_f = take_token(gs_a, TK_REDIR);
        o_ok = (gs_f == GS_IN_CMD) || (gs_f == GS_AFTER_AMP);
    end

    // Next state: everything returns to reset after the final byte
    always_comb begin
        n_gs   = gs_a;
        n_pend = pend_a;
        if (i_last) begin
            n_gs   = GS_EXPECT_CMD;
            n_pend = PEND_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs      <= GS_EXPECT_CMD;
            r_pend    <= PEND_NONE;
            r_in_name <= 1'b0;
            r_stop    <= 1'b0;
        end else if (i_en) begin
            r_gs      <= n_gs;
            r_pend    <= n_pend;
            r_in_name <= i_last ? 1'b0 : n_in_name;
            r_stop    <= i_last ? 1'b0 : n_stop;
        end
    end

endmodule

FILE: design/shell_command_line_validator_top.sv
// ----------------------------------------------------------------------------
// shell_command_line_validator_top
// Path: the verdict of a line whose final byte is accepted reaches o_valid
//   through the input register, then the result register.
// Throughput: one byte word per cycle; a final byte waits in the input
//   register while an unaccepted verdict still holds the result register.
// Reset: synchronous, active low; clears both stages and the line state.
// ----------------------------------------------------------------------------
module shell_command_line_validator_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_valid_res
);
    import scv_pkg::*;

    logic       r_s1_valid;
    logic [7:0] r_s1_ch;
    logic       r_s1_last;
    logic       r_out_valid;
    logic       r_out_res;

    logic out_free;
    logic s1_adv;
    logic ok;

    // Handshake: a non-final byte always moves on, a final one needs the result slot
    assign out_free = !r_out_valid || i_ready;
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    assign o_ready  = !r_s1_valid || s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_ch   <= i_ch;
            r_s1_last <= i_last;
        end
    end

    scv_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s1_adv),
        .i_ch    (r_s1_ch),
        .i_last  (r_s1_last),
        .o_ok    (ok)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_adv && r_s1_last) begin
            r_out_res <= ok;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_valid_res = r_out_res;

endmodule

FILE: design/scv_checker.sv
// ----------------------------------------------------------------------------
// scv_checker
// Port-level checks on the validator's handshakes and result timing.
// ----------------------------------------------------------------------------
module scv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_ch,
    input logic       i_last,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_valid_res
);

    // Stalled result word stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_valid_res))
        else $error("result word dropped or changed while stalled");

    // Nothing comes out right after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word present after reset");

    // A fresh result follows an accepted final byte on the input
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && o_ready && i_last, 2))
        else $error("result word without a final byte");

    // Empty result slot never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result slot");

endmodule

bind shell_command_line_validator_top scv_checker u_scv_checker (.*);

FILE: dv/scv_checker.sv
// ----------------------------------------------------------------------------
// scv_checker
// Watches the byte channel and the verdict channel of the command line
// validator. It tracks lexer and grammar state for every accepted byte word,
// queues the verdict of each finished line, and compares every verdict word
// that leaves the block against the oldest queued one.
// ----------------------------------------------------------------------------
module scv_tb_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_valid_res,
    output int         o_fail_cnt,
    output int         o_expected_cnt
);
    timeunit 1ns;
    timeprecision 1ps;

    import scv_pkg::*;

    // Line state mirrored from the byte stream
    t_gs   gstate;
    t_pend held_op;
    logic  in_name;
    logic  stopped;

    logic  line_verdicts[$];
    logic  want;
    int    lines_checked;

    initial o_fail_cnt = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH line %0d: %s", $realtime, lines_checked, msg);
        o_fail_cnt++;
    endtask

    // Grammar step for one token
    function automatic t_gs grammar_next(input t_gs s, input t_tok tk);
        case (s)
            GS_EXPECT_CMD, GS_NEED_TARGET, GS_AFTER_AMP: begin
                return (tk == TK_NAME) ? GS_IN_CMD : GS_ERROR;
            end
            GS_IN_CMD: begin
                case (tk)
                    TK_NAME:             return GS_IN_CMD;
                    TK_REDIR:            return GS_NEED_TARGET;
                    TK_PIPE, TK_ANDAND:  return GS_EXPECT_CMD;
                    TK_AMP:              return GS_AFTER_AMP;
                    default:             return GS_ERROR;
                endcase
            end
            default: return GS_ERROR;
        endcase
    endfunction

    // A held '&' or '>' becomes a token of its own
    task automatic flush_held();
        if (held_op == PEND_AMP) gstate = grammar_next(gstate, TK_AMP);
        else if (held_op == PEND_GT) gstate = grammar_next(gstate, TK_REDIR);
        held_op = PEND_NONE;
    endtask

    task automatic clear_line();
        gstate  = GS_EXPECT_CMD;
        held_op = PEND_NONE;
        in_name = 1'b0;
        stopped = 1'b0;
    endtask

    // Lexer: one byte of the line
    task automatic line_byte(input logic [7:0] c);
        if (held_op == PEND_AMP && c == C_AMP) begin
            held_op = PEND_NONE;
            gstate  = grammar_next(gstate, TK_ANDAND);
        end else if (held_op == PEND_GT && c == C_GT) begin
            held_op = PEND_NONE;
            gstate  = grammar_next(gstate, TK_REDIR);
        end else begin
            flush_held();
            if (c == C_NUL) begin
                stopped = 1'b1;
                in_name = 1'b0;
            end else if (c == C_SPACE || (c >= C_TAB && c <= C_CR)) begin
                in_name = 1'b0;
            end else if (c == C_AMP) begin
                in_name = 1'b0;
                held_op = PEND_AMP;
            end else if (c == C_GT) begin
                in_name = 1'b0;
                held_op = PEND_GT;
            end else if (c == C_PIPE) begin
                in_name = 1'b0;
                gstate  = grammar_next(gstate, TK_PIPE);
            end else if (c == C_LT) begin
                in_name = 1'b0;
                gstate  = grammar_next(gstate, TK_REDIR);
            end else if (!in_name) begin
                in_name = 1'b1;
                gstate  = grammar_next(gstate, TK_NAME);
            end
        end
    endtask

    // Compare verdicts, then absorb the accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            line_verdicts.delete();
            lines_checked = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (line_verdicts.size() == 0) begin
                    report_mismatch($sformatf("verdict %b with no line pending", i_valid_res));
                end else begin
                    want = line_verdicts.pop_front();
                    if (i_valid_res !== want)
                        report_mismatch($sformatf("valid_res got %b want %b",
                                                  i_valid_res, want));
                end
                lines_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                if (!stopped) line_byte(i_ch);
                if (i_last) begin
                    flush_held();
                    line_verdicts.push_back(gstate == GS_IN_CMD || gstate == GS_AFTER_AMP);
                    clear_line();
                end
            end
        end
        o_expected_cnt = line_verdicts.size();
    end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds command lines byte by byte into the validator: a few directed lines
// for operators and corner cases, then random well-formed, damaged and noise
// lines, with random idle bursts on both channels and one long output stall.
// The checker beside the block does the predicting and comparing.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_WORDS   = 1050;
    localparam int PRESSURE_AT    = 300;
    localparam int QUIET_AT       = 900;
    localparam int HOLD_CYCLES    = 80;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic [7:0] i_ch;
    logic       i_last;
    logic       i_ready;
    logic       o_ready;
    logic       o_valid;
    logic       o_valid_res;

    int         fail_cnt;
    int         expected_cnt;
    int         words_sent  = 0;
    int         idle_cycles = 0;
    bit         hold_req    = 1'b0;
    bit         hold_done   = 1'b0;
    bit         quiet       = 1'b0;
    bit         gaps_on     = 1'b1;

    logic [7:0] line_bytes[$];

    shell_command_line_validator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_valid_res (o_valid_res)
    );

    scv_tb_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_ch           (i_ch),
        .i_last         (i_last),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_valid_res    (o_valid_res),
        .o_fail_cnt     (fail_cnt),
        .o_expected_cnt (expected_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: too long without any word moving
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Verdict receiver: random stalls, one long hold-off
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one byte word; returns in the step it is accepted
    task automatic send_word(input logic [7:0] c, input logic l);
        if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        i_last  <= l;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
        if (words_sent >= PRESSURE_AT) hold_req = 1'b1;
        if (words_sent >= QUIET_AT) quiet = 1'b1;
    endtask

    task automatic send_line();
        if (line_bytes.size() == 0) line_bytes.push_back(C_SPACE);
        for (int k = 0; k < line_bytes.size(); k++)
            send_word(line_bytes[k], k == line_bytes.size() - 1);
        line_bytes.delete();
    endtask

    task automatic push_str(input string s);
        for (int k = 0; k < s.len(); k++) line_bytes.push_back(s[k]);
    endtask

    function automatic logic [7:0] blank_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? C_SPACE : C_TAB + 8'(r);
    endfunction

    // Mostly letters, some high bytes and punctuation
    function automatic logic [7:0] name_byte();
        int r;
        logic [7:0] c;
        r = $urandom_range(0, 9);
        if (r < 6) c = 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 8) c = 8'($urandom_range(128, 255));
        else begin
            c = 8'($urandom_range(33, 126));
            if (c == C_AMP || c == C_LT || c == C_GT || c == C_PIPE) c = 8'h5F;
        end
        return c;
    endfunction

    function automatic logic [7:0] op_byte();
        case ($urandom_range(0, 3))
            0:       return C_AMP;
            1:       return C_PIPE;
            2:       return C_LT;
            default: return C_GT;
        endcase
    endfunction

    task automatic add_name();
        repeat ($urandom_range(1, 4)) line_bytes.push_back(name_byte());
    endtask

    task automatic add_gap(input bit forced);
        if (forced || $urandom_range(0, 1))
            repeat ($urandom_range(1, 2)) line_bytes.push_back(blank_byte());
    endtask

    // Command name with arguments and redirections
    task automatic add_atomic();
        add_name();
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 3))
                0: begin
                    add_gap(1);
                end
                1: begin
                    add_gap(0);
                    line_bytes.push_back(C_LT);
                    add_gap(0);
                end
                2: begin
                    add_gap(0);
                    line_bytes.push_back(C_GT);
                    add_gap(0);
                end
                default: begin
                    add_gap(0);
                    line_bytes.push_back(C_GT);
                    line_bytes.push_back(C_GT);
                    add_gap(0);
                end
            endcase
            add_name();
        end
    endtask

    // Pipelines chained by & or &&, optional trailing &
    task automatic build_command_line();
        int groups;
        groups = $urandom_range(1, 3);
        add_gap(0);
        for (int g = 0; g < groups; g++) begin
            if (g > 0) begin
                add_gap(0);
                line_bytes.push_back(C_AMP);
                if ($urandom_range(0, 1)) line_bytes.push_back(C_AMP);
                add_gap(0);
            end
            add_atomic();
            repeat ($urandom_range(0, 2)) begin
                add_gap(0);
                line_bytes.push_back(C_PIPE);
                add_gap(0);
                add_atomic();
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            add_gap(0);
            line_bytes.push_back(C_AMP);
        end
        add_gap(0);
    endtask

    task automatic damage_line();
        int idx;
        idx = $urandom_range(0, line_bytes.size() - 1);
        case ($urandom_range(0, 3))
            0:       if (line_bytes.size() > 1) line_bytes.delete(idx);
            1:       line_bytes[idx] = 8'($urandom_range(0, 255));
            2:       line_bytes.insert(idx, C_NUL);
            default: line_bytes.push_back(op_byte());
        endcase
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 3))
                0:       line_bytes.push_back(8'($urandom_range(0, 255)));
                1:       line_bytes.push_back(op_byte());
                2:       line_bytes.push_back(blank_byte());
                default: line_bytes.push_back(name_byte());
            endcase
        end
    endtask

    // Main stimulus
    initial begin
        int kind;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ch    <= 8'h00;
        i_last  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: trailing &, missing target, blank and empty lines,
        // split &, every operator, high byte, bytes after NUL
        push_str("a&");       send_line();
        push_str("a>");       send_line();
        push_str(" ");        send_line();
        line_bytes.push_back(C_NUL);
        send_line();
        push_str("a& &");     send_line();
        push_str("a&&b");     send_line();
        push_str("a|b>>c");   send_line();
        line_bytes.push_back(8'hFF);
        send_line();
        push_str("b<c");      send_line();
        line_bytes.push_back(8'h61);
        line_bytes.push_back(C_NUL);
        line_bytes.push_back(C_PIPE);
        send_line();

        // Random lines
        while (words_sent < TARGET_WORDS) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 20) build_noise();
            else begin
                build_command_line();
                if (kind < 40) damage_line();
            end
            send_line();
        end
        i_valid <= 1'b0;

        // Drain outstanding verdicts, then allow the pipeline to settle
        @(posedge i_clk);
        wait (expected_cnt == 0);
        repeat (8) @(posedge i_clk);
        if (fail_cnt == 0 && expected_cnt == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/scv_pkg.sv
design/scv_step.sv
design/shell_command_line_validator_top.sv
design/scv_checker.sv
dv/scv_checker.sv
dv/tb_top.sv
